// ===== rtl/elc_pkg.sv =====
// Shared types and constants for the EEPROM line cache.
package elc_pkg;

  // Host opcodes carried on the input channel.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_FILL  = 2'd3
  } opcode_t;

  // Result kinds carried on the output channel.
  typedef enum logic [1:0] {
    KIND_STORE_WRITE = 2'd0,
    KIND_FILL_REQ    = 2'd1,
    KIND_READ_DATA   = 2'd2
  } kind_t;

  // A failed fill makes the whole line read as this value.
  localparam logic [7:0] FAILED_BYTE = 8'hFF;

  // Source of the word loaded into the output register.
  typedef enum logic [1:0] {
    OSEL_HOLD = 2'd0,
    OSEL_REQ  = 2'd1,
    OSEL_HIT  = 2'd2,
    OSEL_FILL = 2'd3
  } out_sel_t;

  // Controller states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DECODE   = 8'b0000_0010,
    ST_FL_RD    = 8'b0000_0100,
    ST_FL_CAP   = 8'b0000_1000,
    ST_FL_END   = 8'b0001_0000,
    ST_FILL_OUT = 8'b0010_0000,
    ST_RD_OUT   = 8'b0100_0000,
    ST_SWEEP    = 8'b1000_0000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;
    logic     clr_fpend;
    logic     fill_write;
    logic     fill_done;
    logic     scan_start;
    logic     scan_step;
    logic     write_commit;
    logic     start_fill;
    logic     capture;
    logic     finish;
    logic     sweep_write;
    logic     out_load;
    out_sel_t out_sel;
    logic     rd_scan;
  } elc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t op;
    logic    fpend;
    logic    off_last;
    logic    modified;
    logic    miss;
    logic    valid;
    logic    ffail;
    logic    scan_last;
    logic    scan_dirty;
    logic    hold_vld;
    logic    out_free;
  } elc_stat_t;

endpackage

// ===== rtl/elc_if.sv =====
// Valid/ready channel interfaces for host items and result words.
interface elc_in_if #(
  parameter int ADDR_BITS = 19
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [ADDR_BITS-1:0] address;
  logic [7:0]           byte_in;
  logic                 fill_error;
  logic                 burst_last;

  modport source (output valid, opcode, address, byte_in, fill_error, burst_last,
                  input ready);
  modport sink (input valid, opcode, address, byte_in, fill_error, burst_last,
                output ready);
endinterface

interface elc_out_if #(
  parameter int ADDR_BITS  = 19,
  parameter int LINE_BYTES = 64
) ();
  localparam int TAG_W = ADDR_BITS - $clog2(LINE_BYTES);

  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [ADDR_BITS-1:0] store_address;
  logic [7:0]           byte_out;
  logic                 run_end;
  logic                 request_fill;
  logic [TAG_W-1:0]     fill_line;
  logic                 access_end;
  logic                 last;

  modport source (output valid, kind, store_address, byte_out, run_end, request_fill,
                  fill_line, access_end, last, input ready);
  modport sink (input valid, kind, store_address, byte_out, run_end, request_fill,
                fill_line, access_end, last, output ready);
endinterface

// ===== rtl/elc_ctrl.sv =====
// Controller state machine that sequences lookups, flush scans, fills and sweeps.
module elc_ctrl
  import elc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  elc_stat_t stat,
  output elc_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.out_sel = OSEL_HOLD;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.op == OP_FILL) begin
          if (!stat.fpend) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.fill_write = 1'b1;
            if (stat.off_last) begin
              // The read issued now picks up the byte the pending read asked for.
              cmd.fill_done = 1'b1;
              state_nxt     = ST_FILL_OUT;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          cmd.clr_fpend = 1'b1;
          case (stat.op)
            OP_FLUSH: begin
              if (stat.modified) begin
                cmd.scan_start = 1'b1;
                state_nxt      = ST_FL_RD;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
            OP_WRITE: begin
              if (stat.miss && stat.modified) begin
                cmd.scan_start = 1'b1;
                state_nxt      = ST_FL_RD;
              end else begin
                cmd.write_commit = 1'b1;
                state_nxt        = ST_IDLE;
              end
            end
            default: begin
              if (stat.modified) begin
                cmd.scan_start = 1'b1;
                state_nxt      = ST_FL_RD;
              end else if (stat.miss || !stat.valid) begin
                if (stat.out_free) begin
                  cmd.start_fill = 1'b1;
                  cmd.out_load   = 1'b1;
                  cmd.out_sel    = OSEL_REQ;
                  state_nxt      = ST_IDLE;
                end
              end else begin
                state_nxt = ST_RD_OUT;
              end
            end
          endcase
        end
      end
      ST_FL_RD: begin
        cmd.rd_scan = 1'b1;
        if (stat.scan_dirty) begin
          state_nxt = ST_FL_CAP;
        end else if (stat.scan_last) begin
          state_nxt = ST_FL_END;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FL_CAP: begin
        cmd.rd_scan = 1'b1;
        if (!stat.hold_vld || stat.out_free) begin
          cmd.capture  = 1'b1;
          cmd.out_load = stat.hold_vld;
          if (stat.scan_last) begin
            state_nxt = ST_FL_END;
          end else begin
            cmd.scan_step = 1'b1;
            state_nxt     = ST_FL_RD;
          end
        end
      end
      ST_FL_END: begin
        cmd.rd_scan = 1'b1;
        if (!stat.hold_vld || stat.out_free) begin
          cmd.finish   = 1'b1;
          cmd.out_load = stat.hold_vld;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FILL_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_FILL;
          if (stat.ffail) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SWEEP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_HIT;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_write = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/elc_datapath.sv =====
// Datapath: line memory, dirty marks, tag state, flush holding stage and output register.
module elc_datapath
  import elc_pkg::*;
#(
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 19
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  elc_cmd_t                                 cmd,
  output elc_stat_t                                stat,
  input  logic [1:0]                               in_opcode,
  input  logic [ADDR_BITS-1:0]                     in_address,
  input  logic [7:0]                               in_byte_in,
  input  logic                                     in_fill_error,
  input  logic                                     in_burst_last,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [1:0]                               out_kind,
  output logic [ADDR_BITS-1:0]                     out_store_address,
  output logic [7:0]                               out_byte_out,
  output logic                                     out_run_end,
  output logic                                     out_request_fill,
  output logic [ADDR_BITS-$clog2(LINE_BYTES)-1:0]  out_fill_line,
  output logic                                     out_access_end,
  output logic                                     out_last
);

  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int TAG_W = ADDR_BITS - OFF_W;
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(LINE_BYTES - 1);

  // Line storage: one write port, one registered read port.
  logic [7:0] mem [LINE_BYTES];
  logic [7:0] rd_data_r;

  // Item registers.
  opcode_t              op_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [7:0]           byte_r;
  logic                 ferr_r;
  logic                 blast_r;

  // Line state.
  logic [LINE_BYTES-1:0] dirty_r, dirty_nxt;
  logic [TAG_W-1:0]      tag_r;
  logic                  valid_r, modified_r, fpend_r, pend_r, ffail_r;
  logic [OFF_W-1:0]      poff_r;

  // Flush scan and holding stage.
  logic [OFF_W-1:0] scan_r;
  logic             hold_vld_r;
  logic [OFF_W-1:0] hold_off_r;
  logic [7:0]       hold_data_r;
  logic             hold_run_end_r;

  // Output register.
  logic                 out_valid_r;
  kind_t                kind_r;
  logic [ADDR_BITS-1:0] saddr_r;
  logic [7:0]           bout_r;
  logic                 run_end_r, req_r, aend_r, last_r;
  logic [TAG_W-1:0]     fline_r;

  logic [OFF_W-1:0] ioff, scan_inc, rd_addr, mem_wa;
  logic [TAG_W-1:0] itag;
  logic             scan_last, next_dirty, mem_we, out_free, ride;
  logic             wr_flush_commit, rd_flush_commit, fill_start;
  logic [7:0]       mem_wd, fill_byte;

  assign ioff      = addr_r[OFF_W-1:0];
  assign itag      = addr_r[ADDR_BITS-1:OFF_W];
  assign scan_last = (scan_r == OFF_LAST);
  assign scan_inc  = scan_r + OFF_W'(1);
  assign next_dirty = !scan_last && dirty_r[scan_inc];
  assign out_free  = !out_valid_r || out_ready;

  assign wr_flush_commit = cmd.finish && (op_r == OP_WRITE);
  assign rd_flush_commit = cmd.finish && (op_r == OP_READ);
  assign fill_start      = cmd.start_fill || rd_flush_commit;
  // The fill request rides on the final write-back word of a read's flush.
  assign ride            = rd_flush_commit;

  assign stat.op         = op_r;
  assign stat.fpend      = fpend_r;
  assign stat.off_last   = (ioff == OFF_LAST);
  assign stat.modified   = modified_r;
  assign stat.miss       = (itag != tag_r);
  assign stat.valid      = valid_r;
  assign stat.ffail      = ffail_r;
  assign stat.scan_last  = scan_last;
  assign stat.scan_dirty = dirty_r[scan_r];
  assign stat.hold_vld   = hold_vld_r;
  assign stat.out_free   = out_free;

  assign rd_addr = cmd.rd_scan ? scan_r : ((op_r == OP_FILL) ? poff_r : ioff);
  assign mem_we  = cmd.fill_write || cmd.write_commit || wr_flush_commit ||
                   cmd.sweep_write;
  assign mem_wa  = cmd.sweep_write ? scan_r : ioff;
  assign mem_wd  = cmd.sweep_write ? FAILED_BYTE : byte_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= opcode_t'(in_opcode);
      addr_r  <= in_address;
      byte_r  <= in_byte_in;
      ferr_r  <= in_fill_error;
      blast_r <= in_burst_last;
    end
  end

  always_comb begin
    dirty_nxt = dirty_r;
    if (cmd.finish) begin
      dirty_nxt = '0;
    end
    if (cmd.write_commit || wr_flush_commit) begin
      dirty_nxt[ioff] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r    <= '0;
      tag_r      <= '0;
      valid_r    <= 1'b0;
      modified_r <= 1'b0;
      fpend_r    <= 1'b0;
      poff_r     <= '0;
      pend_r     <= 1'b0;
      ffail_r    <= 1'b0;
      scan_r     <= '0;
      hold_vld_r <= 1'b0;
    end else begin
      dirty_r <= dirty_nxt;
      if (cmd.write_commit || fill_start || wr_flush_commit) begin
        tag_r   <= itag;
        valid_r <= 1'b0;
      end else if (cmd.fill_done) begin
        valid_r <= 1'b1;
      end
      if (cmd.write_commit) begin
        modified_r <= 1'b1;
      end else if (cmd.finish) begin
        modified_r <= wr_flush_commit;
      end
      if (fill_start) begin
        fpend_r <= 1'b1;
        poff_r  <= ioff;
        pend_r  <= blast_r;
        ffail_r <= 1'b0;
      end else begin
        if (cmd.clr_fpend || cmd.fill_done) begin
          fpend_r <= 1'b0;
        end
        if (cmd.fill_write) begin
          ffail_r <= ffail_r | ferr_r;
        end
      end
      if (cmd.scan_start) begin
        scan_r     <= '0;
        hold_vld_r <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_r <= scan_inc;
        end
        if (cmd.capture) begin
          hold_vld_r <= 1'b1;
        end else if (cmd.finish) begin
          hold_vld_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hold_off_r     <= scan_r;
      hold_data_r    <= rd_data_r;
      hold_run_end_r <= !next_dirty;
    end
  end

  // On completion the last fill byte is being written as it is needed, so it bypasses.
  assign fill_byte = ffail_r ? FAILED_BYTE :
                     ((poff_r == OFF_LAST) ? byte_r : rd_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind_r    <= KIND_READ_DATA;
      saddr_r   <= '0;
      bout_r    <= '0;
      run_end_r <= 1'b0;
      req_r     <= 1'b0;
      fline_r   <= '0;
      aend_r    <= 1'b0;
      last_r    <= 1'b1;
      case (cmd.out_sel)
        OSEL_HOLD: begin
          kind_r    <= KIND_STORE_WRITE;
          saddr_r   <= {tag_r, hold_off_r};
          bout_r    <= hold_data_r;
          run_end_r <= hold_run_end_r;
          req_r     <= ride;
          fline_r   <= ride ? itag : '0;
          last_r    <= cmd.finish;
        end
        OSEL_REQ: begin
          kind_r  <= KIND_FILL_REQ;
          req_r   <= 1'b1;
          fline_r <= itag;
        end
        OSEL_HIT: begin
          bout_r <= rd_data_r;
          aend_r <= blast_r;
        end
        OSEL_FILL: begin
          bout_r <= fill_byte;
          aend_r <= pend_r;
        end
        default: begin
          kind_r <= KIND_READ_DATA;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_store_address = saddr_r;
  assign out_byte_out      = bout_r;
  assign out_run_end       = run_end_r;
  assign out_request_fill  = req_r;
  assign out_fill_line     = fline_r;
  assign out_access_end    = aend_r;
  assign out_last          = last_r;

endmodule

// ===== rtl/eeprom_line_cache_top.sv =====
// Top level of the single-line write-back EEPROM cache.
// A write hit, a clean-miss read or a fill byte is finished in the decode state after acceptance (a read
// waits there for a free output register); a read hit or the line-completing fill byte gives its word
// from a later output state. A flush walks every offset of the line, with a capture step for each
// dirty byte; the single line memory port sets this pace.
// A failed fill adds a pass that writes 0xFF into every line byte.
// Reset is synchronous: valid, dirty and pending-fill state clear; line data is left unset.
module eeprom_line_cache_top
  import elc_pkg::*;
#(
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 19
) (
  input  logic        clk,
  input  logic        rst_n,
  elc_in_if.sink      in_ch,
  elc_out_if.source   out_ch
);

  // Line size must be a power of two: the address splits into tag and offset bits.
  localparam int TAG_W = ADDR_BITS - $clog2(LINE_BYTES);

  elc_cmd_t  cmd;
  elc_stat_t stat;
  logic      in_ready;

  logic             out_valid, out_run_end, out_request_fill, out_access_end, out_last;
  logic [1:0]       out_kind;
  logic [7:0]       out_byte_out;
  logic [ADDR_BITS-1:0] out_store_address;
  logic [TAG_W-1:0] out_fill_line;

  // The controller only sees status; all line state lives in the datapath.
  elc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  elc_datapath #(
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_ch.opcode),
    .in_address        (in_ch.address),
    .in_byte_in        (in_ch.byte_in),
    .in_fill_error     (in_ch.fill_error),
    .in_burst_last     (in_ch.burst_last),
    .out_valid         (out_valid),
    .out_ready         (out_ch.ready),
    .out_kind          (out_kind),
    .out_store_address (out_store_address),
    .out_byte_out      (out_byte_out),
    .out_run_end       (out_run_end),
    .out_request_fill  (out_request_fill),
    .out_fill_line     (out_fill_line),
    .out_access_end    (out_access_end),
    .out_last          (out_last)
  );

  // A new item is taken only in the idle state; a finished word may still sit in the
  // output register while it is taken.
  assign in_ch.ready = in_ready;

  assign out_ch.valid         = out_valid;
  assign out_ch.kind          = out_kind;
  assign out_ch.store_address = out_store_address;
  assign out_ch.byte_out      = out_byte_out;
  assign out_ch.run_end       = out_run_end;
  assign out_ch.request_fill  = out_request_fill;
  assign out_ch.fill_line     = out_fill_line;
  assign out_ch.access_end    = out_access_end;
  assign out_ch.last          = out_last;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the single-line EEPROM write-back cache.
`timescale 1ns / 1ps

module tb_top;
  import elc_pkg::*;

  localparam int LINE_LEN      = 64;
  localparam int ADDR_W        = 19;
  localparam int OFF_W         = 6;
  localparam int TAG_W         = ADDR_W - OFF_W;
  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 350;
  // Settle time: room for a full flush walk plus a failed-fill sweep, with margin.
  localparam int SETTLE_CYCLES = 2 * LINE_LEN + 3 + LINE_LEN + 16;
  localparam int LONG_HOLD     = 800;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int MAX_REPORTS   = 40;

  // One host item as it travels on the input channel.
  typedef struct packed {
    opcode_t           op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              ferr;
    logic              blast;
  } host_item_t;

  // One result word as it leaves on the output channel.
  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] saddr;
    logic [7:0]        data;
    logic              run_end;
    logic              req;
    logic [TAG_W-1:0]  line;
    logic              aend;
    logic              last;
  } cache_word_t;

  // How the words of a stimulus row are checked.
  typedef enum logic [1:0] {
    CHK_PREDICTED,
    CHK_NO_WORD,
    CHK_TYPED
  } row_check_t;

  typedef struct {
    host_item_t  item;
    row_check_t  how;
    cache_word_t word;
  } stim_row_t;

  // Receiver stall patterns; each one runs for a random number of cycles.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_TOGGLE,
    RDY_HALF,
    RDY_SPARSE
  } ready_pattern_t;

  logic clk = 1'b0;
  logic rst_n;

  elc_in_if  #(.ADDR_BITS(ADDR_W)) in_ch ();
  elc_out_if #(.ADDR_BITS(ADDR_W), .LINE_BYTES(LINE_LEN)) out_ch ();

  eeprom_line_cache_top #(
    .LINE_BYTES(LINE_LEN),
    .ADDR_BITS (ADDR_W)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cache predictor. It keeps its own copy of the line, the per-byte dirty
  // marks, the tag and the fill bookkeeping, and works out the words that each
  // accepted host item produces. byte_known tracks which line bytes have ever
  // been written, so that stimulus never reads a byte that holds no data.
  // ---------------------------------------------------------------------------
  logic [7:0]       cached_bytes [LINE_LEN];
  bit               byte_dirty   [LINE_LEN];
  bit               byte_known   [LINE_LEN];
  logic [TAG_W-1:0] cached_tag;
  bit               cached_valid;
  bit               cached_modified;
  bit               fill_open;
  logic [OFF_W-1:0] fill_offset;
  bit               fill_end;
  bit               fill_failing;

  cache_word_t item_words[$];      // words caused by the item just accepted
  cache_word_t expected_words[$];  // words still owed by the block, oldest first
  cache_word_t no_word = '0;
  stim_row_t   directed_rows[$];

  int          error_count = 0;
  int          items_taken = 0;
  int          burst_left = 0;
  int          long_hold_request = 0;
  logic [TAG_W-1:0] tag_pool [4];

  function automatic cache_word_t mk_word(kind_t kind, logic [ADDR_W-1:0] saddr,
                                          logic [7:0] data, logic run_end, logic req,
                                          logic [TAG_W-1:0] line, logic aend, logic last);
    cache_word_t w;
    w.kind    = kind;
    w.saddr   = saddr;
    w.data    = data;
    w.run_end = run_end;
    w.req     = req;
    w.line    = line;
    w.aend    = aend;
    w.last    = last;
    return w;
  endfunction

  function automatic host_item_t host_item(opcode_t op, logic [ADDR_W-1:0] addr,
                                           logic [7:0] data, logic ferr, logic blast);
    host_item_t it;
    it.op    = op;
    it.addr  = addr;
    it.data  = data;
    it.ferr  = ferr;
    it.blast = blast;
    return it;
  endfunction

  // Write every dirty byte back in ascending order; a byte ends a run when the
  // next offset is clean or it is the last byte of the line.
  function automatic void write_back_line();
    if (!cached_modified) return;
    for (int i = 0; i < LINE_LEN; i++) begin
      if (byte_dirty[i])
        item_words.push_back(mk_word(KIND_STORE_WRITE, {cached_tag, OFF_W'(i)},
                                     cached_bytes[i],
                                     (i == LINE_LEN - 1) ? 1'b1 : !byte_dirty[i + 1],
                                     1'b0, '0, 1'b0, 1'b0));
    end
    foreach (byte_dirty[i]) byte_dirty[i] = 1'b0;
    cached_modified = 1'b0;
  endfunction

  // Returns 1 when the item is a fill byte that the block simply drops.
  function automatic bit predict_cache_words(host_item_t it);
    logic [TAG_W-1:0] tag;
    logic [OFF_W-1:0] off;
    cache_word_t      w;
    tag = it.addr[ADDR_W-1:OFF_W];
    off = it.addr[OFF_W-1:0];
    item_words.delete();
    if (it.op == OP_FILL) begin
      if (!fill_open) return 1'b1;
      cached_bytes[off] = it.data;
      byte_known[off]   = 1'b1;
      if (it.ferr) fill_failing = 1'b1;
      if (off != OFF_W'(LINE_LEN - 1)) return 1'b0;
      // The byte for the top offset completes the line; any error in the fill
      // turns the whole line into the failed-byte pattern.
      if (fill_failing) begin
        foreach (cached_bytes[i]) begin
          cached_bytes[i] = FAILED_BYTE;
          byte_known[i]   = 1'b1;
        end
      end
      cached_valid = 1'b1;
      fill_open    = 1'b0;
      item_words.push_back(mk_word(KIND_READ_DATA, '0, cached_bytes[fill_offset], 1'b0,
                                   1'b0, '0, fill_end, 1'b1));
      return 1'b0;
    end
    // Any other item abandons a fill in progress.
    fill_open = 1'b0;
    if (it.op == OP_FLUSH) begin
      write_back_line();
    end else if (it.op == OP_WRITE) begin
      if (tag != cached_tag) begin
        write_back_line();
        cached_tag = tag;
      end
      cached_bytes[off] = it.data;
      byte_known[off]   = 1'b1;
      byte_dirty[off]   = 1'b1;
      cached_valid      = 1'b0;
      cached_modified   = 1'b1;
    end else begin
      if (cached_modified || tag != cached_tag) begin
        write_back_line();
        cached_tag   = tag;
        cached_valid = 1'b0;
      end
      if (!cached_valid) begin
        fill_open    = 1'b1;
        fill_offset  = off;
        fill_end     = it.blast;
        fill_failing = 1'b0;
        // After a flush the fill request rides on the last write-back word.
        if (item_words.size() != 0) begin
          w      = item_words.pop_back();
          w.req  = 1'b1;
          w.line = tag;
          item_words.push_back(w);
        end else begin
          item_words.push_back(mk_word(KIND_FILL_REQ, '0, '0, 1'b0, 1'b1, tag, 1'b0, 1'b0));
        end
      end else begin
        item_words.push_back(mk_word(KIND_READ_DATA, '0, cached_bytes[off], 1'b0, 1'b0, '0,
                                     it.blast, 1'b0));
      end
    end
    if (item_words.size() != 0) begin
      w      = item_words.pop_back();
      w.last = 1'b1;
      item_words.push_back(w);
    end
    return 1'b0;
  endfunction

  // Keep stimulus away from line bytes that were never written. A completing
  // fill that would hand back such a byte is marked as failed instead, and a
  // read hit on one becomes a flush.
  function automatic host_item_t defined_reads_only(host_item_t it);
    host_item_t fixed;
    fixed = it;
    if (it.op == OP_FILL && fill_open && it.addr[OFF_W-1:0] == OFF_W'(LINE_LEN - 1) &&
        !fill_failing && !it.ferr && !byte_known[fill_offset] &&
        fill_offset != OFF_W'(LINE_LEN - 1))
      fixed.ferr = 1'b1;
    if (it.op == OP_READ && cached_valid && !cached_modified &&
        it.addr[ADDR_W-1:OFF_W] == cached_tag && !byte_known[it.addr[OFF_W-1:0]])
      fixed.op = OP_FLUSH;
    return fixed;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length; between bursts valid drops
  // for a random gap. Each item is predicted at the edge where it is accepted,
  // so the predictor state always matches what the block has taken so far.
  // A caller that lets time pass between items must lower valid first.
  // ---------------------------------------------------------------------------
  task automatic offer_item(host_item_t raw, row_check_t how, cache_word_t typed);
    host_item_t it;
    bit         ignored;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // Now and then a long burst with no gaps at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 16);
    end
    it = defined_reads_only(raw);
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= it.op;
    in_ch.address    <= it.addr;
    in_ch.byte_in    <= it.data;
    in_ch.fill_error <= it.ferr;
    in_ch.burst_last <= it.blast;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    ignored = predict_cache_words(it);
    if (!ignored) items_taken++;
    if (how == CHK_PREDICTED) begin
      foreach (item_words[i]) expected_words.push_back(item_words[i]);
    end else if (how == CHK_TYPED) begin
      expected_words.push_back(typed);
    end
  endtask

  task automatic wait_for_drain();
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 4) == 0) return TAG_W'($urandom);
    return tag_pool[$urandom_range(0, 3)];
  endfunction

  // A group of writes into one line, either at consecutive offsets starting at
  // first (wrapping inside the line) or at scattered offsets.
  task automatic send_writes(logic [TAG_W-1:0] tag, logic [OFF_W-1:0] first, int count,
                             bit in_order);
    logic [OFF_W-1:0] off;
    off = first;
    repeat (count) begin
      offer_item(host_item(OP_WRITE, {tag, in_order ? off : OFF_W'($urandom)}, 8'($urandom),
                           1'($urandom), 1'($urandom)), CHK_PREDICTED, no_word);
      off++;
    end
  endtask

  // Fill bytes for the open fill, in ascending offset order. Most sequences
  // skip ahead but stop on the requested offset; some carry the whole line,
  // and some break off before the top offset so the fill stays open.
  task automatic feed_fill_bytes();
    int         mode;
    logic [6:0] off;
    logic [6:0] nxt;
    bit         done;
    mode = $urandom_range(0, 9);
    off  = (mode == 0) ? 7'd0 : 7'($urandom_range(0, 15));
    done = 1'b0;
    while (!done) begin
      offer_item(host_item(OP_FILL, {TAG_W'($urandom), off[OFF_W-1:0]}, 8'($urandom),
                           $urandom_range(0, (mode == 0) ? 255 : 31) == 0, 1'($urandom)),
                 CHK_PREDICTED, no_word);
      if (off == 7'(LINE_LEN - 1) || (mode == 1 && $urandom_range(0, 3) == 0)) begin
        done = 1'b1;
      end else begin
        nxt = (mode == 0) ? off + 7'd1 : off + 7'($urandom_range(1, 16));
        if (off < {1'b0, fill_offset} && nxt > {1'b0, fill_offset}) nxt = {1'b0, fill_offset};
        off = (nxt > 7'(LINE_LEN - 1)) ? 7'(LINE_LEN - 1) : nxt;
      end
    end
  endtask

  // A read, usually answered by the store, then a few reads of the same line
  // that hit if the fill completed.
  task automatic send_read_and_fill(logic [TAG_W-1:0] tag);
    offer_item(host_item(OP_READ, {tag, OFF_W'($urandom)}, 8'($urandom), 1'($urandom),
                         1'($urandom)), CHK_PREDICTED, no_word);
    if (fill_open && $urandom_range(0, 9) != 0) feed_fill_bytes();
    repeat ($urandom_range(0, 3))
      offer_item(host_item(OP_READ, {tag, OFF_W'($urandom)}, 8'($urandom), 1'($urandom),
                           1'($urandom)), CHK_PREDICTED, no_word);
  endtask

  function automatic void add_row(opcode_t op, logic [ADDR_W-1:0] addr, logic [7:0] data,
                                  logic ferr, logic blast, row_check_t how, cache_word_t word);
    stim_row_t row;
    row.item = host_item(op, addr, data, ferr, blast);
    row.how  = how;
    row.word = word;
    directed_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver. Ready follows a pattern that is redrawn at random intervals.
  // A long hold-off, when requested, overrides the pattern and is counted
  // down here so that the sender keeps offering items meanwhile.
  // ---------------------------------------------------------------------------
  initial begin
    ready_pattern_t pattern;
    int             pattern_left;
    int             hold_left;
    pattern      = RDY_ALWAYS;
    pattern_left = 0;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_request != 0) begin
        hold_left         = long_hold_request;
        long_hold_request = 0;
      end
      if (pattern_left == 0) begin
        pattern      = ready_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 128);
      end else begin
        pattern_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (pattern)
          RDY_ALWAYS: out_ch.ready <= 1'b1;
          RDY_TOGGLE: out_ch.ready <= ~out_ch.ready;
          RDY_HALF:   out_ch.ready <= 1'($urandom);
          default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every word taken from the block is compared, field by
  // field, with the oldest word still expected.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, cache_word_t seen, cache_word_t want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t %s: got kind=%0d addr=%h byte=%h run_end=%b fill=%b line=%h end=%b last=%b;"
               , $realtime, what, seen.kind, seen.saddr, seen.data, seen.run_end, seen.req,
               seen.line, seen.aend, seen.last,
               " wanted kind=%0d addr=%h byte=%h run_end=%b fill=%b line=%h end=%b last=%b",
               want.kind, want.saddr, want.data, want.run_end, want.req, want.line,
               want.aend, want.last);
  endtask

  always @(posedge clk) begin
    cache_word_t seen;
    cache_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = mk_word(kind_t'(out_ch.kind), out_ch.store_address, out_ch.byte_out,
                     out_ch.run_end, out_ch.request_fill, out_ch.fill_line,
                     out_ch.access_end, out_ch.last);
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected", seen, no_word);
      end else begin
        want = expected_words.pop_front();
        if (seen !== want) report_mismatch("word differs", seen, want);
      end
    end
  end

  // Hard limit on the whole run.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random traffic with one drain pause
  // and one long receiver hold-off, then wait for the last words.
  // ---------------------------------------------------------------------------
  initial begin
    logic [TAG_W-1:0] tag;
    int               pick;
    bit               paused_once;
    bit               pressed_once;
    paused_once  = 1'b0;
    pressed_once = 1'b0;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_WRITE;
    in_ch.address    <= '0;
    in_ch.byte_in    <= '0;
    in_ch.fill_error <= 1'b0;
    in_ch.burst_last <= 1'b0;

    foreach (cached_bytes[i]) begin
      cached_bytes[i] = '0;
      byte_dirty[i]   = 1'b0;
      byte_known[i]   = 1'b0;
    end
    cached_tag      = '0;
    cached_valid    = 1'b0;
    cached_modified = 1'b0;
    fill_open       = 1'b0;
    fill_offset     = '0;
    fill_end        = 1'b0;
    fill_failing    = 1'b0;

    // Directed table. Typed words are the ones obvious from the cache rules:
    // results straight after reset, fill requests at the address extremes and
    // the failed-fill pattern. Everything else is left to the predictor.
    // A flush of a clean line and a stray fill byte do nothing after reset.
    add_row(OP_FLUSH, 19'h00000, 8'h00, 1'b0, 1'b0, CHK_NO_WORD, no_word);
    add_row(OP_FILL,  19'h0003F, 8'h5C, 1'b0, 1'b0, CHK_NO_WORD, no_word);
    // A read of line 0 finds it clean but not valid and asks for a fill.
    add_row(OP_READ,  19'h00000, 8'h00, 1'b0, 1'b1, CHK_TYPED,
            mk_word(KIND_FILL_REQ, '0, 8'h00, 1'b0, 1'b1, 13'h0000, 1'b0, 1'b1));
    // Completing byte with an error: the line reads as the failed pattern.
    add_row(OP_FILL,  19'h0003F, 8'h12, 1'b1, 1'b0, CHK_TYPED,
            mk_word(KIND_READ_DATA, '0, FAILED_BYTE, 1'b0, 1'b0, '0, 1'b1, 1'b1));
    add_row(OP_READ,  19'h00005, 8'h00, 1'b0, 1'b0, CHK_TYPED,
            mk_word(KIND_READ_DATA, '0, FAILED_BYTE, 1'b0, 1'b0, '0, 1'b0, 1'b1));
    // Writes to the top line at both ends and in the middle, then a flush
    // that yields runs of one and two bytes.
    add_row(OP_WRITE, 19'h7FFFF, 8'hFF, 1'b0, 1'b0, CHK_NO_WORD, no_word);
    add_row(OP_WRITE, 19'h7FFC0, 8'h00, 1'b0, 1'b0, CHK_NO_WORD, no_word);
    add_row(OP_WRITE, 19'h7FFC1, 8'hA5, 1'b0, 1'b1, CHK_NO_WORD, no_word);
    add_row(OP_WRITE, 19'h7FFC3, 8'h5A, 1'b1, 1'b0, CHK_NO_WORD, no_word);
    add_row(OP_FLUSH, 19'h00000, 8'h00, 1'b0, 1'b0, CHK_PREDICTED, no_word);
    add_row(OP_FLUSH, 19'h7FFFF, 8'hFF, 1'b1, 1'b1, CHK_NO_WORD, no_word);
    // A read of a modified line flushes it and the fill request rides on the
    // last write-back word; the fill then completes without error.
    add_row(OP_WRITE, 19'h00040, 8'h11, 1'b0, 1'b0, CHK_NO_WORD, no_word);
    add_row(OP_READ,  19'h00040, 8'h00, 1'b0, 1'b1, CHK_PREDICTED, no_word);
    add_row(OP_FILL,  19'h0003F, 8'h99, 1'b0, 1'b0, CHK_PREDICTED, no_word);
    // Writing into the cached line makes it not valid, so the read refetches.
    add_row(OP_WRITE, 19'h00045, 8'h77, 1'b0, 1'b0, CHK_NO_WORD, no_word);
    add_row(OP_READ,  19'h00045, 8'h00, 1'b0, 1'b0, CHK_PREDICTED, no_word);
    // A write during the fill abandons it; the late fill byte is dropped.
    add_row(OP_WRITE, 19'h00046, 8'h33, 1'b0, 1'b0, CHK_NO_WORD, no_word);
    add_row(OP_FILL,  19'h0003F, 8'h44, 1'b0, 1'b0, CHK_NO_WORD, no_word);
    add_row(OP_READ,  19'h00046, 8'h00, 1'b0, 1'b0, CHK_PREDICTED, no_word);
    // A flush during the fill abandons it too, and the line is clean by now.
    add_row(OP_FLUSH, 19'h00000, 8'h00, 1'b0, 1'b0, CHK_NO_WORD, no_word);
    // Top line miss, an error on an early fill byte that sticks to the end.
    add_row(OP_READ,  19'h7FFFF, 8'h00, 1'b0, 1'b1, CHK_TYPED,
            mk_word(KIND_FILL_REQ, '0, 8'h00, 1'b0, 1'b1, 13'h1FFF, 1'b0, 1'b1));
    add_row(OP_FILL,  19'h0000A, 8'h00, 1'b1, 1'b0, CHK_NO_WORD, no_word);
    add_row(OP_FILL,  19'h7FFFF, 8'h00, 1'b0, 1'b0, CHK_TYPED,
            mk_word(KIND_READ_DATA, '0, FAILED_BYTE, 1'b0, 1'b0, '0, 1'b1, 1'b1));
    add_row(OP_READ,  19'h7FFC0, 8'h00, 1'b0, 1'b1, CHK_TYPED,
            mk_word(KIND_READ_DATA, '0, FAILED_BYTE, 1'b0, 1'b0, '0, 1'b1, 1'b1));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_item(directed_rows[i].item, directed_rows[i].how, directed_rows[i].word);

    // A small pool of lines gives plenty of hits; the rest of the address
    // space is reached by the occasional fully random tag.
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = TAG_W'($urandom);
    tag_pool[3] = TAG_W'($urandom);

    items_taken = 0;
    while (items_taken < RANDOM_ITEMS) begin
      if (!paused_once && items_taken >= 120) begin
        // The sender stops until the block has handed over every word.
        paused_once = 1'b1;
        in_ch.valid <= 1'b0;
        burst_left = 0;
        wait_for_drain();
      end
      if (!pressed_once && items_taken >= 220) begin
        // The receiver holds off while a full dirty line is written and then
        // evicted, so that the flush backs up and the input stalls.
        pressed_once      = 1'b1;
        long_hold_request = LONG_HOLD;
        tag = pick_tag();
        send_writes(tag, '0, LINE_LEN, 1'b1);
        send_writes(tag + 1'b1, OFF_W'($urandom), 3, 1'b1);
        send_read_and_fill(tag + 1'b1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        tag = pick_tag();
        if ($urandom_range(0, 24) == 0)
          send_writes(tag, '0, LINE_LEN, 1'b1);
        else
          send_writes(tag, OFF_W'($urandom), $urandom_range(1, 6), 1'($urandom));
      end else if (pick < 75) begin
        send_read_and_fill(pick_tag());
      end else if (pick < 88) begin
        offer_item(host_item(OP_FLUSH, ADDR_W'($urandom), 8'($urandom), 1'($urandom),
                             1'($urandom)), CHK_PREDICTED, no_word);
      end else begin
        // Noise: any opcode with any field values.
        offer_item(host_item(opcode_t'($urandom_range(0, 3)), ADDR_W'($urandom), 8'($urandom),
                             1'($urandom), 1'($urandom)), CHK_PREDICTED, no_word);
      end
    end

    in_ch.valid <= 1'b0;
    wait_for_drain();
    // Leave room for any stray word the block might still emit.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
